FILE: hdl/pse_pkg.sv
// Shared constants, codes and controller/datapath interface types for the postfix evaluator.
`timescale 1ns / 1ps
package pse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 64;
  localparam int HALF_W      = DATA_W / 2;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 3;

  // token kinds
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  // expression status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER  = 3'd4;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_NEXT,
    RD_BASE
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_R,
    S_RD_L,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WB,
    S_FINISH,
    S_RD0,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                capture;
    logic                push;
    logic                set_err;
    logic [STATUS_W-1:0] err_code;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                cap_r;
    logic                cap_l;
    logic                mul_start;
    logic                mul_step;
    logic                div_start;
    logic                wb;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic in_err;
    logic op_push;
    logic op_arith;
    logic op_mul;
    logic op_div;
    logic full;
    logic under;
    logic r_zero;
    logic last;
    logic emit;
    logic final_read;
    logic mul_done;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/pse_div.sv
// Iterative radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module pse_div
  import pse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic              neg_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign busy    = (cnt_r != '0);
  assign quotient = neg_r ? (~quo_r + {{(DATA_W-1){1'b0}}, 1'b1}) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DATA_W);
    end else if (busy) begin
      cnt_r <= cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[DATA_W-1] ? (~dividend + {{(DATA_W-1){1'b0}}, 1'b1}) : dividend;
      dvs_r <= divisor[DATA_W-1] ? (~divisor + {{(DATA_W-1){1'b0}}, 1'b1}) : divisor;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      if (!diff[DATA_W+1]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/pse_dp.sv
// Datapath: token register, operand stack memory, depth/error, add/sub, mul, div, output word.
`timescale 1ns / 1ps
module pse_dp
  import pse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [DATA_W-1:0]   in_tdata,
  input  logic [OP_W-1:0]     in_tuser,
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_tdata,
  output logic [STATUS_W-1:0] out_tuser,
  output logic                out_tlast
);

  logic [OP_W-1:0]     op_r;
  logic [DATA_W-1:0]   val_r;
  logic                last_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [STATUS_W-1:0] err_r;
  logic                emit_r;

  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   rdata_r;
  logic [DATA_W-1:0]   r_r;
  logic [DATA_W-1:0]   l_r;
  logic [DATA_W-1:0]   res_r;

  logic [1:0]          mul_cnt_r;
  logic [DATA_W-1:0]   prod_r;
  logic [DATA_W-1:0]   acc_r;
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;

  logic                out_valid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_last_r;

  logic [DEPTH_W-1:0]  depth_m1;
  logic [DEPTH_W-1:0]  depth_m2;
  logic [PTR_W-1:0]    rd_addr;
  logic [PTR_W-1:0]    wr_addr;
  logic                wr_en;
  logic [DATA_W-1:0]   wr_data;
  logic [DATA_W-1:0]   res_nxt;
  logic                div_busy;
  logic [DATA_W-1:0]   div_q;
  logic [STATUS_W-1:0] fin_status;
  logic [DATA_W-1:0]   fin_value;

  assign depth_m1 = depth_r - {{(DEPTH_W-1){1'b0}}, 1'b1};
  assign depth_m2 = depth_r - {{(DEPTH_W-2){1'b0}}, 2'd2};

  always_comb begin
    unique case (cmd.rd_sel)
      RD_TOP:  rd_addr = depth_m1[PTR_W-1:0];
      RD_NEXT: rd_addr = depth_m2[PTR_W-1:0];
      RD_BASE: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  assign wr_en   = cmd.push || cmd.wb;
  assign wr_addr = cmd.push ? depth_r[PTR_W-1:0] : depth_m2[PTR_W-1:0];
  assign wr_data = cmd.push ? val_r : res_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // token, operand and result capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tuser;
      val_r  <= in_tdata;
      last_r <= in_tlast;
    end
    if (cmd.cap_r) begin
      r_r <= rdata_r;
    end
    if (cmd.cap_l) begin
      l_r <= rdata_r;
    end
    if (cmd.wb) begin
      res_r <= res_nxt;
    end
  end

  // 64x64 low product from three 32x32 partial products
  always_comb begin
    unique case (mul_cnt_r)
      2'd0:    begin mul_a = l_r[HALF_W-1:0];      mul_b = r_r[HALF_W-1:0];      end
      2'd1:    begin mul_a = l_r[HALF_W-1:0];      mul_b = r_r[DATA_W-1:HALF_W]; end
      default: begin mul_a = l_r[DATA_W-1:HALF_W]; mul_b = r_r[HALF_W-1:0];      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (cmd.mul_start) begin
      mul_cnt_r <= '0;
    end else if (cmd.mul_step) begin
      mul_cnt_r <= mul_cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      prod_r <= mul_a * mul_b;
      if (mul_cnt_r == 2'd1) begin
        acc_r <= prod_r;
      end else if (mul_cnt_r != 2'd0) begin
        acc_r <= acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
      end
    end
  end

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (l_r),
    .divisor  (r_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    unique case (op_r)
      OP_ADD:  res_nxt = l_r + r_r;
      OP_SUB:  res_nxt = l_r - r_r;
      OP_MUL:  res_nxt = acc_r;
      default: res_nxt = div_q;
    endcase
  end

  // depth, error and emit flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= ST_OK;
      emit_r  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        emit_r <= 1'b0;
      end
      if (cmd.push) begin
        depth_r <= depth_r + {{(DEPTH_W-1){1'b0}}, 1'b1};
      end
      if (cmd.wb) begin
        depth_r <= depth_m1;
        emit_r  <= 1'b1;
      end
      if (cmd.set_err) begin
        err_r <= cmd.err_code;
      end
      if (cmd.load_out && last_r) begin
        depth_r <= '0;
        err_r   <= ST_OK;
      end
    end
  end

  // closing status of the expression
  always_comb begin
    fin_status = err_r;
    fin_value  = '0;
    if (err_r == ST_OK) begin
      if (depth_r == '0) begin
        fin_status = ST_UNDERFLOW;
      end else if (depth_r != {{(DEPTH_W-1){1'b0}}, 1'b1}) begin
        fin_status = ST_LEFTOVER;
      end else begin
        fin_value = rdata_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r   <= last_r ? fin_value : res_r;
      out_status_r <= last_r ? fin_status : ST_OK;
      out_last_r   <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    sts.in_err     = (err_r != ST_OK);
    sts.op_push    = (op_r == OP_PUSH);
    sts.op_arith   = (op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_MUL) ||
                     (op_r == OP_DIV);
    sts.op_mul     = (op_r == OP_MUL);
    sts.op_div     = (op_r == OP_DIV);
    sts.full       = (depth_r >= DEPTH_W'(STACK_DEPTH));
    sts.under      = (depth_r < {{(DEPTH_W-2){1'b0}}, 2'd2});
    sts.r_zero     = (r_r == '0);
    sts.last       = last_r;
    sts.emit       = emit_r;
    sts.final_read = (err_r == ST_OK) && (depth_r == {{(DEPTH_W-1){1'b0}}, 1'b1});
    sts.mul_done   = (mul_cnt_r == 2'd3);
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule

FILE: hdl/pse_ctrl.sv
// Controller state machine: sequences stack reads, arithmetic, write-back and output per token.
`timescale 1ns / 1ps
module pse_ctrl
  import pse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (!sts.in_err && sts.op_arith && !sts.under) state_nxt = S_RD_R;
        else                                           state_nxt = S_FINISH;
      end
      S_RD_R:   state_nxt = S_RD_L;
      S_RD_L:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.op_mul)                     state_nxt = S_MUL;
        else if (sts.op_div && sts.r_zero)  state_nxt = S_FINISH;
        else if (sts.op_div)                state_nxt = S_DIV;
        else                                state_nxt = S_WB;
      end
      S_MUL:    if (sts.mul_done) state_nxt = S_WB;
      S_DIV:    if (!sts.div_busy) state_nxt = S_WB;
      S_WB:     state_nxt = S_FINISH;
      S_FINISH: begin
        priority if (sts.last && sts.final_read) state_nxt = S_RD0;
        else if (sts.last || sts.emit)           state_nxt = S_OUT;
        else                                     state_nxt = S_IDLE;
      end
      S_RD0:    state_nxt = S_OUT;
      S_OUT:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = RD_TOP;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_CHECK: begin
        if (!sts.in_err) begin
          if (sts.op_push) begin
            if (sts.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (sts.op_arith) begin
            if (sts.under) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_UNDERFLOW;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
            end
          end
        end
      end
      S_RD_R: begin
        cmd.cap_r  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
      end
      S_RD_L: begin
        cmd.cap_l = 1'b1;
      end
      S_EXEC: begin
        if (sts.op_mul) begin
          cmd.mul_start = 1'b1;
        end else if (sts.op_div && sts.r_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZERO;
        end else if (sts.op_div) begin
          cmd.div_start = 1'b1;
        end
      end
      S_MUL:    cmd.mul_step = 1'b1;
      S_DIV:    ;
      S_WB:     cmd.wb = 1'b1;
      S_FINISH: begin
        if (sts.last && sts.final_read) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BASE;
        end
      end
      S_RD0:    ;
      S_OUT:    cmd.load_out = sts.out_free;
      default:  ;
    endcase
  end

endmodule

FILE: hdl/postfix_stack_evaluator.sv
// Postfix expression evaluator top level: controller and datapath joined by command/status.
// Flow: a token is taken only in idle; an arithmetic token reads its operands, computes and
//   writes back, multiply and divide iterating; a last token that leaves one result and no
//   error also reads the stack base; divide is the slowest token. The output register lets
//   the next token in before a word is taken.
// Reset: synchronous, active low; empties the stack, clears the error and drops any held word.
`timescale 1ns / 1ps
module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // token input
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DATA_W-1:0]   in_tdata,    // [63:0] operand
  input  logic [OP_W-1:0]     in_tuser,    // [2:0] op
  input  logic                in_tlast,    // last token of the expression
  // result output
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_tdata,   // [63:0] result_value
  output logic [STATUS_W-1:0] out_tuser,   // [2:0] status
  output logic                out_tlast    // end_of_expr
);

  cmd_t cmd;
  sts_t sts;

  // sequence each token: check, read operands, compute, write back, emit
  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the stack, the arithmetic units and the output word
  pse_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/tb_postfix_stack_evaluator.sv
// Self-checking testbench for the postfix stack evaluator: random and directed token streams.
`timescale 1ns / 1ps
module tb_postfix_stack_evaluator;
  import pse_pkg::*;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] operand;
    logic              last;
  } token_t;

  typedef struct {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
    logic                eoe;
  } result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;   // [63:0] operand
  logic [OP_W-1:0]     in_tuser;   // [2:0] op
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [DATA_W-1:0]   out_tdata;  // [63:0] result_value
  logic [STATUS_W-1:0] out_tuser;  // [2:0] status
  logic                out_tlast;

  postfix_stack_evaluator i_dut (.*);

  // Shadow copy of the evaluator state
  logic [DATA_W-1:0]   shadow_stack [STACK_DEPTH];
  int unsigned         shadow_depth;
  logic [STATUS_W-1:0] shadow_err;

  token_t  pending_tokens[$];
  result_t expected_results[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      hold_send;
  bit      in_taken;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  task automatic add_token(input token_t t);
    pending_tokens.insert(pending_tokens.size(), t);
  endtask

  task automatic add_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Work out the result a token produces, if any, and advance the shadow state.
  task automatic evaluate_token(input token_t t);
    logic [DATA_W-1:0]   r, l, res;
    logic [STATUS_W-1:0] st;
    logic [DATA_W-1:0]   v;
    bit                  emit;
    emit = 0;
    res  = '0;
    if (shadow_err == ST_OK) begin
      if (t.op == OP_PUSH) begin
        if (shadow_depth >= STACK_DEPTH) shadow_err = ST_FULL;
        else begin
          shadow_stack[shadow_depth] = t.operand;
          shadow_depth++;
        end
      end else if (t.op <= OP_DIV) begin
        if (shadow_depth < 2) shadow_err = ST_UNDERFLOW;
        else begin
          r = shadow_stack[shadow_depth-1];
          l = shadow_stack[shadow_depth-2];
          case (t.op)
            OP_ADD: res = l + r;
            OP_SUB: res = l - r;
            OP_MUL: res = l * r;
            default: begin
              if (r == '0) shadow_err = ST_DIVZERO;
              else if (l == {1'b1, {(DATA_W-1){1'b0}}} && r == '1) res = l;
              else res = $signed(l) / $signed(r);
            end
          endcase
          if (shadow_err == ST_OK) begin
            shadow_depth--;
            shadow_stack[shadow_depth-1] = res;
            emit = 1;
          end
        end
      end
    end
    if (t.last) begin
      st = shadow_err;
      v  = '0;
      if (st == ST_OK) begin
        if (shadow_depth == 0) st = ST_UNDERFLOW;
        else if (shadow_depth > 1) st = ST_LEFTOVER;
        else v = shadow_stack[0];
      end
      add_result('{v, st, 1'b1});
      shadow_depth = 0;
      shadow_err   = ST_OK;
    end else if (emit) begin
      add_result('{res, ST_OK, 1'b0});
    end
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: rand_value = {1'b1, 63'd0};
      1: rand_value = {1'b0, {63{1'b1}}};
      2: rand_value = '0;
      3: rand_value = DATA_W'($signed($urandom_range(0, 20)) - 10);
      default: rand_value = {$urandom, $urandom};
    endcase
  endfunction

  // Queue a well-formed expression with random content, sometimes broken.
  task automatic queue_expression();
    int n, live, k;
    logic [OP_W-1:0] op;
    n = ($urandom_range(0, 20) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
    live = 0;
    for (k = 0; k < n; k++) begin
      add_token('{OP_PUSH, rand_value(), 1'b0});
      live++;
      while (live >= 2 && $urandom_range(0, 2) != 0) begin
        op = OP_W'($urandom_range(OP_ADD, OP_DIV));
        add_token('{op, {$urandom, $urandom}, 1'b0});
        live--;
      end
    end
    while (live > 1) begin
      // Weight divide lightly; it is the slow path.
      op = ($urandom_range(0, 5) == 0) ? OP_DIV : OP_W'($urandom_range(OP_ADD, OP_MUL));
      add_token('{op, {$urandom, $urandom}, 1'b0});
      live--;
    end
    // Break some sequences: stray operator, bad opcode or dropped close.
    if ($urandom_range(0, 9) == 0)
      add_token('{OP_W'($urandom_range(0, 7)), {$urandom, $urandom}, 1'b0});
    pending_tokens[$].last = ($urandom_range(0, 9) != 0);
    if (!pending_tokens[$].last)
      add_token('{OP_W'($urandom_range(0, 7)), rand_value(), 1'b1});
  endtask

  // Driver: present tokens at the falling edge, hold until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the current word
    end else if (pending_tokens.size() > 0 && !hold_send &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      in_tvalid <= 1'b1;
      in_tuser  <= pending_tokens[0].op;
      in_tdata  <= pending_tokens[0].operand;
      in_tlast  <= pending_tokens[0].last;
      void'(pending_tokens.pop_front());
    end else begin
      in_tvalid <= 1'b0;
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predict on accepted tokens, compare accepted result words.
  always @(posedge clk) begin
    result_t exp_r;
    in_taken = in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        evaluate_token('{in_tuser, in_tdata, in_tlast});
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result word: value %h status %0d last %b",
                     out_tdata, out_tuser, out_tlast);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata !== exp_r.value || out_tuser !== exp_r.status ||
              out_tlast !== exp_r.eoe) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected value %h status %0d last %b, got %h %0d %b",
                       exp_r.value, exp_r.status, exp_r.eoe, out_tdata, out_tuser, out_tlast);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_tokens.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int i;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = OP_PUSH; in_tlast = 1'b0;
    out_tready = 1'b0; in_taken = 1'b0;
    mismatches = 0; shadow_depth = 0; shadow_err = ST_OK; hold_send = 0;
    send_idle_pct = 15; recv_idle_pct = 68;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every operator on extreme values.
    add_token('{OP_PUSH, {1'b1, 63'd0}, 1'b0});
    add_token('{OP_PUSH, '1, 1'b0});
    add_token('{OP_DIV, '0, 1'b0});      // most negative over minus one
    add_token('{OP_PUSH, {1'b0, {63{1'b1}}}, 1'b0});
    add_token('{OP_ADD, '1, 1'b0});
    add_token('{OP_PUSH, 64'd3, 1'b0});
    add_token('{OP_MUL, '0, 1'b0});
    add_token('{OP_PUSH, -64'sd7, 1'b0});
    add_token('{OP_DIV, '0, 1'b0});      // truncating divide
    add_token('{OP_PUSH, 64'd5, 1'b0});
    add_token('{OP_SUB, '0, 1'b1});
    add_token('{OP_ADD, '0, 1'b1});      // operator on empty stack
    add_token('{OP_PUSH, 64'd9, 1'b0});
    add_token('{OP_PUSH, 64'd0, 1'b0});
    add_token('{OP_DIV, '0, 1'b0});      // divide by zero
    add_token('{OP_ADD, '0, 1'b0});      // ignored while in error
    add_token('{3'd7, '0, 1'b1});        // bad opcode closes expression
    add_token('{3'd5, '0, 1'b1});        // last token, empty stack
    add_token('{OP_PUSH, 64'd1, 1'b0});
    add_token('{OP_PUSH, 64'd2, 1'b1});  // leftover operands
    for (i = 0; i <= STACK_DEPTH; i++)   // overfill the stack
      add_token('{OP_PUSH, {$urandom, $urandom}, i == STACK_DEPTH});
    wait_drained();

    // Hold the sender while the expressions are queued, then drain them.
    hold_send = 1;
    for (i = 0; i < 30; i++) queue_expression();
    hold_send = 0;
    wait_drained();

    for (i = 0; i < 3; i++) begin
      if (i == 1) begin send_idle_pct = 68; recv_idle_pct = 15; end
      if (i == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      while (pending_tokens.size() < 400) queue_expression();
      wait_drained();
    end
    repeat (200) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hdl/pse_pkg.sv
hdl/pse_div.sv
hdl/pse_dp.sv
hdl/pse_ctrl.sv
hdl/postfix_stack_evaluator.sv
tb/tb_postfix_stack_evaluator.sv
